/* rtl/core/bfrm_pkg.sv */
// shared types and constants for the beam frame rotation matrix block
package bfrm_pkg;

  localparam int NUM_AXES   = 3;
  localparam int COMP_BITS  = 32;
  localparam int THR_BITS   = 31;
  localparam int MAG_BITS   = 31;
  localparam int SHIFT_BITS = 7;
  localparam int ROOT_BITS  = 32;
  localparam int SQRT_STEPS = 32;
  localparam int RAW_BITS   = 64;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BEAM_ZERO = 2'd1,
    ST_COLLINEAR = 2'd2
  } status_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][MAG_BITS-1:0] ms;
    logic [NUM_AXES-1:0]               neg;
    logic [SHIFT_BITS-1:0]             s;
  } norm_side_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } norm_flags_t;

endpackage

/* rtl/core/beam_frame_rotation_matrix.sv */
// top level: builds the orthonormal beam frame matrix from a beam and an eta vector
// One vector pair enters per clock unless the output is held off. Each pair passes the
// input product register, the two normalizers (five stages of prescale and square sum,
// a 32-step integer square root, one threshold compare stage and an OUT_FRAC_BITS+1-step
// divider, root and divider running one bit per pipeline stage), then the final cross
// product register and the output register. The beam and the eta x beam normalizers run
// side by side. When the output is held off, the whole pipeline stalls together and
// in_tready drops. The threshold is applied deep inside the normalizers, so cfg_data
// must be written only while no item is in flight; the block itself does not enforce it.
module beam_frame_rotation_matrix #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [30:0]  cfg_data,      // zero_norm_threshold
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,      // beam_x, beam_y, beam_z, eta_x, eta_y, eta_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,     // row0_col0 .. row2_col2, row-major
  output logic [1:0]   out_tuser      // status
);
  import bfrm_pkg::*;

  localparam int HW = OUT_FRAC_BITS + 2;
  localparam int PW = 2 * HW;
  localparam logic [PW:0] RND = (PW+1)'(1) << (OUT_FRAC_BITS - 1);
  localparam logic [PW:0] LIM = (PW+1)'(1) << OUT_FRAC_BITS;

  logic [THR_BITS-1:0] thr_r;
  logic                en;
  logic                out_tvalid_r;
  logic [287:0]        out_tdata_r;
  logic [1:0]          out_tuser_r;

  assign cfg_ready = 1'b1;
  assign en        = !(out_tvalid_r && !out_tready);
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // input stage: register beam and the eta x beam partial products
  logic signed [COMP_BITS-1:0] b_in [NUM_AXES];
  logic signed [COMP_BITS-1:0] e_in [NUM_AXES];
  logic signed [RAW_BITS-1:0]  p_nxt [6];
  logic signed [COMP_BITS-1:0] b1_r [NUM_AXES];
  logic signed [RAW_BITS-1:0]  p_r [6];
  logic                        v1_r;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      b_in[i] = $signed(in_tdata[COMP_BITS*i +: COMP_BITS]);
      e_in[i] = $signed(in_tdata[COMP_BITS*(NUM_AXES+i) +: COMP_BITS]);
    end
    p_nxt[0] = e_in[1] * b_in[2];
    p_nxt[1] = b_in[1] * e_in[2];
    p_nxt[2] = e_in[2] * b_in[0];
    p_nxt[3] = b_in[2] * e_in[0];
    p_nxt[4] = e_in[0] * b_in[1];
    p_nxt[5] = b_in[0] * e_in[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r <= b_in;
      p_r  <= p_nxt;
    end
  end

  // magnitudes and signs for both normalizers
  logic [RAW_BITS-1:0]  y_w [NUM_AXES];
  logic [RAW_BITS-1:0]  ymag [NUM_AXES];
  logic [NUM_AXES-1:0]  yneg;
  logic [COMP_BITS-1:0] bmag [NUM_AXES];
  logic [NUM_AXES-1:0]  bneg;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      y_w[i]  = RAW_BITS'(p_r[2*i] - p_r[2*i+1]);
      yneg[i] = y_w[i][RAW_BITS-1];
      ymag[i] = yneg[i] ? RAW_BITS'(-y_w[i]) : y_w[i];
      bneg[i] = b1_r[i][COMP_BITS-1];
      bmag[i] = bneg[i] ? COMP_BITS'(-b1_r[i]) : COMP_BITS'(b1_r[i]);
    end
  end

  norm_flags_t              bflags, yflags;
  logic signed [HW-1:0]     bh [NUM_AXES];
  logic signed [HW-1:0]     yh [NUM_AXES];

  bfrm_norm #(
    .MW  (COMP_BITS),
    .OFB (OUT_FRAC_BITS)
  ) u_beam_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v1_r),
    .in_mag    (bmag),
    .in_neg    (bneg),
    .thr       (RAW_BITS'(thr_r)),
    .out_flags (bflags),
    .out_hat   (bh)
  );

  bfrm_norm #(
    .MW  (RAW_BITS),
    .OFB (OUT_FRAC_BITS)
  ) u_y_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v1_r),
    .in_mag    (ymag),
    .in_neg    (yneg),
    .thr       (RAW_BITS'(thr_r) << IN_FRAC_BITS),
    .out_flags (yflags),
    .out_hat   (yh)
  );

  // final cross product products
  logic signed [PW-1:0] xp_nxt [6];
  logic signed [PW-1:0] xp_r [6];
  logic signed [HW-1:0] bh_r [NUM_AXES];
  logic signed [HW-1:0] yh_r [NUM_AXES];
  status_t              st_nxt, st_r;
  logic                 vx_r;

  always_comb begin
    xp_nxt[0] = bh[1] * yh[2];
    xp_nxt[1] = yh[1] * bh[2];
    xp_nxt[2] = bh[2] * yh[0];
    xp_nxt[3] = yh[2] * bh[0];
    xp_nxt[4] = bh[0] * yh[1];
    xp_nxt[5] = yh[0] * bh[1];
    if (bflags.zero) begin
      st_nxt = ST_BEAM_ZERO;
    end else if (yflags.zero) begin
      st_nxt = ST_COLLINEAR;
    end else begin
      st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= 1'b0;
    end else if (en) begin
      vx_r <= bflags.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r <= xp_nxt;
      bh_r <= bh;
      yh_r <= yh;
      st_r <= st_nxt;
    end
  end

  // rounding, saturation and output register
  logic [287:0] tdata_nxt;

  always_comb begin
    logic signed [PW:0]     d;
    logic [PW:0]            dm;
    logic [PW:0]            rs;
    logic [OUT_FRAC_BITS:0] mq;
    logic signed [HW-1:0]   xv;
    logic signed [HW-1:0]   nb;
    tdata_nxt = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      d  = xp_r[2*i] - xp_r[2*i+1];
      dm = d[PW] ? (PW+1)'(-d) : (PW+1)'(d);
      rs = (dm + RND) >> OUT_FRAC_BITS;
      mq = (rs > LIM) ? LIM[OUT_FRAC_BITS:0] : rs[OUT_FRAC_BITS:0];
      xv = d[PW] ? -$signed(HW'(mq)) : $signed(HW'(mq));
      nb = -bh_r[i];
      if (st_r == ST_OK) begin
        tdata_nxt[COMP_BITS*(3*i)   +: COMP_BITS] = COMP_BITS'(xv);
        tdata_nxt[COMP_BITS*(3*i+1) +: COMP_BITS] = COMP_BITS'(yh_r[i]);
        tdata_nxt[COMP_BITS*(3*i+2) +: COMP_BITS] = COMP_BITS'(nb);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= tdata_nxt;
      out_tuser_r <= st_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    yflags.valid == bflags.valid)
    else $error("normalizer pipelines out of step");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tuser_r != ST_OK |-> out_tdata_r == '0)
    else $error("matrix not cleared on error status");

  a_beam_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tuser_r == ST_OK |->
      (out_tdata_r[COMP_BITS*2 +: COMP_BITS] != '0 ||
       out_tdata_r[COMP_BITS*5 +: COMP_BITS] != '0 ||
       out_tdata_r[COMP_BITS*8 +: COMP_BITS] != '0))
    else $error("beam column empty on good frame");

endmodule

/* rtl/core/bfrm_norm.sv */
// pipelined vector normalizer: prescale, square sum, integer root, per-axis divide
module bfrm_norm #(
  parameter int MW  = 64,
  parameter int OFB = 30
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [MW-1:0]                   in_mag [bfrm_pkg::NUM_AXES],
  input  logic [bfrm_pkg::NUM_AXES-1:0]   in_neg,
  input  logic [bfrm_pkg::RAW_BITS-1:0]   thr,
  output bfrm_pkg::norm_flags_t           out_flags,
  output logic signed [OFB+1:0]           out_hat [bfrm_pkg::NUM_AXES]
);
  import bfrm_pkg::*;

  localparam int HW = OFB + 2;
  localparam int QW = OFB + 1;
  localparam int NW = MAG_BITS + QW;
  localparam logic signed [HW-1:0] HAT_MAX = HW'(1) <<< OFB;

  // prescale and square sum stages
  logic [MW-1:0]         ma_r [NUM_AXES];
  logic [NUM_AXES-1:0]   nega_r;
  logic                  va_r;
  logic [MW-1:0]         mb_r [NUM_AXES];
  logic [NUM_AXES-1:0]   negb_r;
  logic [SHIFT_BITS-1:0] sb_r;
  logic                  vb_r;
  norm_side_t            sdc_r, sdd_r, sde_r;
  logic                  vc_r, vd_r, ve_r;
  logic [2*MAG_BITS-1:0] sq_r [NUM_AXES];
  logic [RAW_BITS-1:0]   sum_r;

  logic [MW-1:0]         orv;
  logic [SHIFT_BITS-1:0] bl;
  logic [SHIFT_BITS-1:0] sb_nxt;
  norm_side_t            sdc_nxt;
  logic [MW-1:0]         sh_tmp;

  always_comb begin
    orv = in_mag[0] & '0;
    orv = ma_r[0] | ma_r[1] | ma_r[2];
    bl = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv[i]) begin
        bl = SHIFT_BITS'(i + 1);
      end
    end
    sb_nxt = (bl > SHIFT_BITS'(MAG_BITS)) ? bl - SHIFT_BITS'(MAG_BITS) : '0;
  end

  always_comb begin
    sdc_nxt = '0;
    sh_tmp = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      sh_tmp = mb_r[i] >> sb_r;
      sdc_nxt.ms[i] = sh_tmp[MAG_BITS-1:0];
    end
    sdc_nxt.neg = negb_r;
    sdc_nxt.s = sb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        ma_r[i] <= in_mag[i];
        mb_r[i] <= ma_r[i];
        sq_r[i] <= (2*MAG_BITS)'(sdc_r.ms[i]) * (2*MAG_BITS)'(sdc_r.ms[i]);
      end
      nega_r <= in_neg;
      negb_r <= nega_r;
      sb_r   <= sb_nxt;
      sdc_r  <= sdc_nxt;
      sdd_r  <= sdc_r;
      sde_r  <= sdd_r;
      sum_r  <= RAW_BITS'(sq_r[0]) + RAW_BITS'(sq_r[1]) + RAW_BITS'(sq_r[2]);
    end
  end

  // integer square root, one result bit per stage
  logic [RAW_BITS-1:0] sx_r  [1:SQRT_STEPS];
  logic [RAW_BITS-1:0] sr_r  [1:SQRT_STEPS];
  norm_side_t          ssd_r [1:SQRT_STEPS];
  logic                sv_r  [1:SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [RAW_BITS-1:0] BIT = RAW_BITS'(1) << (RAW_BITS - 2 - 2*k);
    logic [RAW_BITS-1:0] x_in, r_in, x_nxt, r_nxt;
    norm_side_t          sd_in;
    logic                v_in;

    if (k == 0) begin : g_first
      assign x_in  = sum_r;
      assign r_in  = '0;
      assign sd_in = sde_r;
      assign v_in  = ve_r;
    end else begin : g_next
      assign x_in  = sx_r[k];
      assign r_in  = sr_r[k];
      assign sd_in = ssd_r[k];
      assign v_in  = sv_r[k];
    end

    always_comb begin
      if (x_in >= r_in + BIT) begin
        x_nxt = x_in - (r_in + BIT);
        r_nxt = (r_in >> 1) + BIT;
      end else begin
        x_nxt = x_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (en) begin
        sv_r[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sx_r[k+1]  <= x_nxt;
        sr_r[k+1]  <= r_nxt;
        ssd_r[k+1] <= sd_in;
      end
    end
  end

  // zero test against threshold
  logic [ROOT_BITS-1:0] nf_r;
  logic                 zf_r;
  norm_side_t           sdf_r;
  logic                 vf_r;
  logic [ROOT_BITS-1:0] n_w;
  logic                 zf_nxt;

  always_comb begin
    n_w = sr_r[SQRT_STEPS][ROOT_BITS-1:0];
    zf_nxt = ((RAW_BITS'(n_w) << ssd_r[SQRT_STEPS].s) <= thr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= sv_r[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nf_r  <= n_w;
      zf_r  <= zf_nxt;
      sdf_r <= ssd_r[SQRT_STEPS];
    end
  end

  // restoring division, one quotient bit per stage
  logic [ROOT_BITS-1:0] dr_r   [1:QW][NUM_AXES];
  logic [QW-1:0]        dl_r   [1:QW][NUM_AXES];
  logic [QW-1:0]        dq_r   [1:QW][NUM_AXES];
  logic [ROOT_BITS-1:0] dn_r   [1:QW];
  logic [NUM_AXES-1:0]  dneg_r [1:QW];
  logic                 dz_r   [1:QW];
  logic                 dv_r   [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [ROOT_BITS-1:0] rem_in [NUM_AXES];
    logic [QW-1:0]        nl_in  [NUM_AXES];
    logic [QW-1:0]        q_in   [NUM_AXES];
    logic [ROOT_BITS-1:0] n_in;
    logic [NUM_AXES-1:0]  neg_in;
    logic                 z_in;
    logic                 v_in;
    logic [ROOT_BITS-1:0] rem_nxt [NUM_AXES];
    logic [QW-1:0]        nl_nxt  [NUM_AXES];
    logic [QW-1:0]        q_nxt   [NUM_AXES];

    if (k == 0) begin : g_first
      logic [NW-1:0] numer [NUM_AXES];
      always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
          numer[i]  = (NW'(sdf_r.ms[i]) << OFB) + NW'(nf_r >> 1);
          rem_in[i] = ROOT_BITS'(numer[i][NW-1:QW]);
          nl_in[i]  = numer[i][QW-1:0];
          q_in[i]   = '0;
        end
      end
      assign n_in   = nf_r;
      assign neg_in = sdf_r.neg;
      assign z_in   = zf_r;
      assign v_in   = vf_r;
    end else begin : g_next
      assign rem_in = dr_r[k];
      assign nl_in  = dl_r[k];
      assign q_in   = dq_r[k];
      assign n_in   = dn_r[k];
      assign neg_in = dneg_r[k];
      assign z_in   = dz_r[k];
      assign v_in   = dv_r[k];
    end

    always_comb begin
      logic [ROOT_BITS:0] t;
      for (int i = 0; i < NUM_AXES; i++) begin
        t = {rem_in[i], nl_in[i][QW-1]};
        if (t >= {1'b0, n_in}) begin
          rem_nxt[i] = ROOT_BITS'(t - {1'b0, n_in});
          q_nxt[i]   = {q_in[i][QW-2:0], 1'b1};
        end else begin
          rem_nxt[i] = t[ROOT_BITS-1:0];
          q_nxt[i]   = {q_in[i][QW-2:0], 1'b0};
        end
        nl_nxt[i] = nl_in[i] << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr_r[k+1]   <= rem_nxt;
        dl_r[k+1]   <= nl_nxt;
        dq_r[k+1]   <= q_nxt;
        dn_r[k+1]   <= n_in;
        dneg_r[k+1] <= neg_in;
        dz_r[k+1]   <= z_in;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      out_hat[i] = dneg_r[QW][i] ? -$signed(HW'(dq_r[QW][i])) : $signed(HW'(dq_r[QW][i]));
    end
    out_flags.valid = dv_r[QW];
    out_flags.zero  = dz_r[QW];
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(out_flags))
    else $error("normalizer output moved during stall");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_flags.valid && !out_flags.zero |->
      out_hat[0] <= HAT_MAX && out_hat[0] >= -HAT_MAX &&
      out_hat[1] <= HAT_MAX && out_hat[1] >= -HAT_MAX &&
      out_hat[2] <= HAT_MAX && out_hat[2] >= -HAT_MAX)
    else $error("unit vector component out of range");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_flags.valid && !out_flags.zero |->
      (out_hat[0] != '0 || out_hat[1] != '0 || out_hat[2] != '0))
    else $error("unit vector is all zero");

endmodule

/* tb/sv/testbench.sv */
// testbench for the beam frame rotation matrix block: directed and random vector pairs
module testbench;
  import bfrm_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [30:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [191:0] in_tdata;       // beam_x, beam_y, beam_z, eta_x, eta_y, eta_z
  logic         out_tvalid;
  logic         out_tready;
  logic [287:0] out_tdata;      // row0_col0 .. row2_col2, row-major
  logic [1:0]   out_tuser;      // status

  typedef struct {
    logic [287:0] mat;
    status_t      st;
  } frame_t;

  beam_frame_rotation_matrix uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  localparam int LATENCY = 72;
  localparam int WATCHDOG = 20000;

  logic [30:0] thr_model;
  frame_t      frames_pending[$];
  int          mismatches;
  int          frames_checked;
  int          items_sent;
  int          idle_cycles;
  bit          gaps_on;
  bit          hold_off;
  int          n_ok, n_zero, n_coll;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit make_unit(input longint v[3], input logic [63:0] lim,
                                   output longint u[3]);
    logic [63:0] m[3];
    logic [63:0] mx, acc, n, q;
    int s;
    mx = 0;
    acc = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >> s) >= (64'd1 << 31)) s++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> s;
      acc = acc + m[i] * m[i];
    end
    n = root64(acc);
    if ((n << s) <= lim) return 0;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (n >> 1)) / n;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic longint cross_round(longint a, longint b, longint c, longint d);
    longint p;
    logic [63:0] m;
    p = a * b - c * d;
    m = p < 0 ? -p : p;
    m = (m + (64'd1 << 29)) >> 30;
    if (m > (64'd1 << 30)) m = 64'd1 << 30;
    return p < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic frame_t predict_frame(logic [191:0] d);
    longint bv[3], ev[3], yv[3], bh[3], yh[3], xh[3];
    frame_t f;
    for (int i = 0; i < 3; i++) begin
      bv[i] = longint'($signed(d[32*i +: 32]));
      ev[i] = longint'($signed(d[96 + 32*i +: 32]));
    end
    f.mat = '0;
    f.st = ST_OK;
    if (!make_unit(bv, 64'(thr_model), bh)) begin
      f.st = ST_BEAM_ZERO;
    end else begin
      yv[0] = ev[1] * bv[2] - bv[1] * ev[2];
      yv[1] = ev[2] * bv[0] - bv[2] * ev[0];
      yv[2] = ev[0] * bv[1] - bv[0] * ev[1];
      if (!make_unit(yv, 64'(thr_model) << 16, yh)) f.st = ST_COLLINEAR;
    end
    if (f.st == ST_OK) begin
      xh[0] = cross_round(bh[1], yh[2], yh[1], bh[2]);
      xh[1] = cross_round(bh[2], yh[0], yh[2], bh[0]);
      xh[2] = cross_round(bh[0], yh[1], yh[0], bh[1]);
      for (int i = 0; i < 3; i++) begin
        f.mat[32*(3*i) +: 32]     = xh[i][31:0];
        f.mat[32*(3*i + 1) +: 32] = yh[i][31:0];
        f.mat[32*(3*i + 2) +: 32] = 32'(-bh[i]);
      end
    end
    return f;
  endfunction

  // receiver side: stall pattern plus long hold-off
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else out_tready <= gaps_on ? ($urandom_range(99) >= 27) : 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    frame_t exp_f;
    if (rst_n && out_tvalid && out_tready) begin
      if (frames_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %h st %0d", out_tdata, out_tuser);
      end else begin
        exp_f = frames_pending.pop_front();
        frames_checked++;
        for (int k = 0; k < 9; k++) begin
          if (out_tdata[32*k +: 32] !== exp_f.mat[32*k +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("entry %0d: expected %0d got %0d", k,
                       $signed(exp_f.mat[32*k +: 32]), $signed(out_tdata[32*k +: 32]));
          end
        end
        if (out_tuser !== exp_f.st) begin
          mismatches++;
          if (mismatches <= 10) $display("status: expected %0d got %0d", exp_f.st, out_tuser);
        end
      end
    end
  end

  // watchdog on transactions
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // valid stays high between items unless random gaps are on; drain drops it
  task automatic send_pair(logic [191:0] d);
    frame_t f;
    while (gaps_on && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    f = predict_frame(d);
    frames_pending.push_back(f);
    items_sent++;
    case (f.st)
      ST_OK:        n_ok++;
      ST_BEAM_ZERO: n_zero++;
      default:      n_coll++;
    endcase
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (frames_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_threshold(logic [30:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thr_model = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [191:0] pack6(int bx, int by, int bz, int ex, int ey, int ez);
    return {ez, ey, ex, bz, by, bx};
  endfunction

  function automatic logic [191:0] rand_pair();
    logic [191:0] d;
    int sh;
    for (int i = 0; i < 6; i++) begin
      sh = $urandom_range(31);
      d[32*i +: 32] = $urandom_range(3) == 0 ? $urandom : ($signed($urandom) >>> sh);
    end
    // collinear and zero-beam cases at random
    case ($urandom_range(9))
      0: d[95:0] = '0;
      1: d[191:96] = d[95:0];
      2: d[191:96] = {-$signed(d[95:64]), -$signed(d[63:32]), -$signed(d[31:0])};
      default: ;
    endcase
    return d;
  endfunction

  task automatic test_directed;
    int mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    send_pair(pack6(0, 0, 0, 65536, 0, 0));
    send_pair(pack6(0, 0, 65536, 65536, 0, 0));
    send_pair(pack6(0, 0, 65536, 0, 0, 65536));
    send_pair(pack6(0, 0, 65536, 0, 0, -65536));
    send_pair(pack6(1, 0, 0, 0, 1, 0));
    send_pair(pack6(2, 0, 0, 0, 1, 0));
    send_pair(pack6(mn, mn, mn, mx, 0, mn));
    send_pair(pack6(mx, mx, mx, mn, mx, 0));
    send_pair(pack6(mn, 0, 0, 0, mn, 0));
    send_pair(pack6(mx, mn, mx, mn, mx, mn));
    send_pair(pack6(-1, -1, -1, 1, -1, 1));
    send_pair(pack6(65536, 65536, 0, 65536, 65536, 1));
    send_pair(pack6(65536, 2*65536, 3*65536, 2*65536, 4*65536, 6*65536));
    send_pair(pack6(-7, 3, 1, 5, -2, 9));
    send_pair(pack6(mx, mx, mx, 0, 0, 0));
    drain();
  endtask

  task automatic test_thresholds;
    logic [30:0] vals[5];
    vals = '{31'd0, 31'h7fff_ffff, 31'd65536, 31'd300, 31'd1};
    foreach (vals[j]) begin
      write_threshold(vals[j]);
      send_pair(pack6(0, 0, 0, 1, 2, 3));
      send_pair(pack6(1, 0, 0, 0, 1, 0));
      send_pair(pack6(65536, 0, 0, 0, 65536, 0));
      for (int i = 0; i < 40; i++) send_pair(rand_pair());
      drain();
    end
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 150; i++) send_pair(rand_pair());
    join
    drain();
  endtask

  task automatic test_random;
    gaps_on = 1'b0;
    for (int i = 0; i < 200; i++) send_pair(rand_pair());
    gaps_on = 1'b1;
    for (int i = 0; i < 600; i++) send_pair(rand_pair());
    drain();
    write_threshold(31'($urandom_range(2000)));
    for (int i = 0; i < 100; i++) send_pair(rand_pair());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    thr_model = 31'd1;
    mismatches = 0;
    frames_checked = 0;
    items_sent = 0;
    idle_cycles = 0;
    gaps_on = 1'b1;
    hold_off = 1'b0;
    n_ok = 0;
    n_zero = 0;
    n_coll = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_thresholds();
    test_backpressure();
    test_random();
    $display("sent %0d vector pairs, checked %0d matrices", items_sent, frames_checked);
    $display("frames built %0d, zero beam %0d, collinear %0d", n_ok, n_zero, n_coll);
    if (mismatches == 0 && frames_pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("mismatches %0d, missing %0d", mismatches, frames_pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
